@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.

// The property must hold at every sampled edge.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The expression must never be true at a sampled edge.
`define ASSERT_NEVER(label, expr) \
    `ASSERT_CLK(label, !(expr))

`endif

@@ design/rls_pkg.sv @@
package rls_pkg;

    typedef enum logic [1:0] {
        KIND_DC  = 2'd0,
        KIND_AC  = 2'd1,
        KIND_ZRL = 2'd2,
        KIND_EOB = 2'd3
    } symbol_kind_t;

    localparam int COEF_W     = 12;
    localparam int RUN_W      = 4;
    localparam int SIZE_W     = 4;
    localparam int AMP_W      = 11;
    localparam int ZCOUNT_W   = 6;
    localparam int ZRL_CNT_W  = 2;

    // Largest magnitude that a DC difference or an AC value may carry.
    localparam logic signed [COEF_W:0] MAG_LIMIT = 13'sd2047;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified item waiting for the back end: zrl_count ZRL symbols
    // followed by one symbol of the given kind built from value.
    typedef struct packed {
        symbol_kind_t               kind;
        logic [ZRL_CNT_W-1:0]       zrl_count;
        logic [RUN_W-1:0]           run;
        logic signed [COEF_W-1:0]   value;
    } rls_job_t;

endpackage

@@ design/rls_coef_if.sv @@
interface rls_coef_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] coefficient;
    logic               block_start;
    logic               predictor_clear;

    modport source (output valid, output coefficient, output block_start,
                    output predictor_clear, input ready);
    modport sink   (input valid, input coefficient, input block_start,
                    input predictor_clear, output ready);
endinterface

@@ design/rls_sym_if.sv @@
interface rls_sym_if;
    logic        valid;
    logic        ready;
    logic [1:0]  symbol_kind;
    logic [3:0]  zero_run;
    logic [3:0]  size_category;
    logic [10:0] amplitude_bits;
    logic        last_of_run;

    modport source (output valid, output symbol_kind, output zero_run,
                    output size_category, output amplitude_bits,
                    output last_of_run, input ready);
    modport sink   (input valid, input symbol_kind, input zero_run,
                    input size_category, input amplitude_bits,
                    input last_of_run, output ready);
endinterface

@@ design/rls_front.sv @@
`include "assert_macros.svh"

module rls_front #(
    parameter int BLOCK_SIDE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    rls_coef_if.sink          coefficients,
    input  logic              queue_full,
    output logic              push,
    output rls_pkg::rls_job_t job
);
    import rls_pkg::*;

    localparam int TOTAL = BLOCK_SIDE * BLOCK_SIDE;
    localparam int POS_W = $clog2(TOTAL);

    logic signed [COEF_W-1:0] prev_dc_reg, prev_dc_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [ZCOUNT_W-1:0]      zero_count_reg, zero_count_next;

    logic                     accept;
    logic                     is_dc;
    logic                     is_last;
    logic                     coef_zero;
    logic signed [COEF_W-1:0] pred;
    logic signed [COEF_W:0]   diff;
    logic signed [COEF_W:0]   diff_sat;
    logic signed [COEF_W-1:0] ac_value;

    assign coefficients.ready = !queue_full;
    assign accept    = coefficients.valid && coefficients.ready;
    assign is_dc     = coefficients.block_start || (pos_reg == '0);
    assign is_last   = (pos_reg == POS_W'(TOTAL - 1));
    assign coef_zero = (coefficients.coefficient == '0);

    // DC difference against the previous block, clamped to +/-2047.
    assign pred = coefficients.predictor_clear ? '0 : prev_dc_reg;
    assign diff = {coefficients.coefficient[COEF_W-1], coefficients.coefficient}
                - {pred[COEF_W-1], pred};

    always_comb
    begin
        if (diff > MAG_LIMIT)
            diff_sat = MAG_LIMIT;
        else if (diff < -MAG_LIMIT)
            diff_sat = -MAG_LIMIT;
        else
            diff_sat = diff;
    end

    // The most negative coefficient has no 11-bit magnitude, so it is clamped.
    assign ac_value = (coefficients.coefficient == {1'b1, {(COEF_W-1){1'b0}}})
                    ? COEF_W'(-MAG_LIMIT) : coefficients.coefficient;

    always_comb
    begin
        push            = 1'b0;
        job.kind        = KIND_DC;
        job.zrl_count   = '0;
        job.run         = '0;
        job.value       = diff_sat[COEF_W-1:0];
        prev_dc_next    = prev_dc_reg;
        pos_next        = pos_reg;
        zero_count_next = zero_count_reg;

        if (accept)
        begin
            if (is_dc)
            begin
                push            = 1'b1;
                prev_dc_next    = coefficients.coefficient;
                pos_next        = POS_W'(1);
                zero_count_next = '0;
            end
            else
            begin
                if (coef_zero)
                begin
                    // A zero only produces a symbol when it closes the block.
                    push      = is_last;
                    job.kind  = KIND_EOB;
                    job.value = '0;
                    if (zero_count_reg != '1)
                        zero_count_next = zero_count_reg + ZCOUNT_W'(1);
                end
                else
                begin
                    // Each full group of sixteen zeros becomes one ZRL.
                    push            = 1'b1;
                    job.kind        = KIND_AC;
                    job.zrl_count   = zero_count_reg[ZCOUNT_W-1:RUN_W];
                    job.run         = zero_count_reg[RUN_W-1:0];
                    job.value       = ac_value;
                    zero_count_next = '0;
                end

                if (is_last)
                begin
                    pos_next        = '0;
                    zero_count_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_dc_reg    <= '0;
            pos_reg        <= '0;
            zero_count_reg <= '0;
        end
        else
        begin
            prev_dc_reg    <= prev_dc_next;
            pos_reg        <= pos_next;
            zero_count_reg <= zero_count_next;
        end
    end

    `ASSERT_CLK(a_dc_opens_block, (accept && is_dc) |=> (pos_reg == POS_W'(1)))
    `ASSERT_CLK(a_last_wraps, (accept && !is_dc && is_last) |=>
                              (pos_reg == '0 && zero_count_reg == '0))

endmodule

@@ design/rls_queue.sv @@
`include "assert_macros.svh"

module rls_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rls_pkg::rls_job_t push_job,
    input  logic              pop,
    output rls_pkg::rls_job_t head,
    output logic              empty,
    output logic              full
);
    import rls_pkg::*;

    rls_job_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            if (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

    `ASSERT_NEVER(a_no_overflow, push && full)
    `ASSERT_NEVER(a_no_underflow, pop && empty)

endmodule

@@ design/rls_back.sv @@
`include "assert_macros.svh"

module rls_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rls_pkg::rls_job_t head,
    input  logic              empty,
    output logic              pop,
    rls_sym_if.source         symbols
);
    import rls_pkg::*;

    logic                   valid_reg, valid_next;
    logic [ZRL_CNT_W-1:0]   zrl_sent_reg, zrl_sent_next;
    symbol_kind_t           kind_reg;
    logic [RUN_W-1:0]       run_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [AMP_W-1:0]       amp_reg;
    logic                   last_reg;

    logic                   advance;
    logic                   load;
    logic                   is_zrl;
    logic [AMP_W-1:0]       magnitude;
    logic [SIZE_W-1:0]      size_cat;
    logic [COEF_W-1:0]      coded;
    logic [AMP_W:0]         amp_mask;

    // Bit length of an 11-bit magnitude.
    function automatic logic [SIZE_W-1:0] bit_length(input logic [AMP_W-1:0] m);
        logic [SIZE_W-1:0] n;
        n = '0;
        for (int i = 0; i < AMP_W; i++)
        begin
            if (m[i])
                n = SIZE_W'(i + 1);
        end
        return n;
    endfunction

    assign advance = !valid_reg || symbols.ready;
    assign load    = advance && !empty;
    assign is_zrl  = (zrl_sent_reg != head.zrl_count);
    assign pop     = load && !is_zrl;

    // Values never reach -2048 here, so the magnitude fits in 11 bits.
    assign magnitude = head.value[COEF_W-1] ? AMP_W'(-head.value)
                                            : head.value[AMP_W-1:0];
    assign size_cat  = bit_length(magnitude);
    // Negative values are sent as one's complement of the magnitude.
    assign coded     = head.value[COEF_W-1] ? (head.value - COEF_W'(1)) : head.value;
    assign amp_mask  = ((AMP_W+1)'(1) << size_cat) - (AMP_W+1)'(1);

    always_comb
    begin
        valid_next    = valid_reg && !symbols.ready;
        zrl_sent_next = zrl_sent_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (is_zrl)
                zrl_sent_next = zrl_sent_reg + ZRL_CNT_W'(1);
            else
                zrl_sent_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            zrl_sent_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            zrl_sent_reg <= zrl_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (is_zrl)
            begin
                kind_reg <= KIND_ZRL;
                run_reg  <= '1;
                size_reg <= '0;
                amp_reg  <= '0;
                last_reg <= 1'b0;
            end
            else
            begin
                kind_reg <= head.kind;
                run_reg  <= head.run;
                size_reg <= size_cat;
                amp_reg  <= coded[AMP_W-1:0] & amp_mask[AMP_W-1:0];
                last_reg <= 1'b1;
            end
        end
    end

    assign symbols.valid          = valid_reg;
    assign symbols.symbol_kind    = kind_reg;
    assign symbols.zero_run       = run_reg;
    assign symbols.size_category  = size_reg;
    assign symbols.amplitude_bits = amp_reg;
    assign symbols.last_of_run    = last_reg;

    `ASSERT_NEVER(a_zrl_bounded, !empty && (zrl_sent_reg > head.zrl_count))
    `ASSERT_CLK(a_zrl_followed, (valid_reg && symbols.ready && kind_reg == KIND_ZRL)
                                |=> valid_reg)

endmodule

@@ design/jpeg_run_length_symbolizer.sv @@
// Run-length symbolizer for baseline JPEG entropy coding, without the Huffman lookup.
// The coefficients channel takes one quantized coefficient per item, in zigzag order,
// BLOCK_SIDE*BLOCK_SIDE items per block; block_start marks the DC item and
// predictor_clear makes that DC difference relative to zero.
// The symbols channel gives DC, AC run/size, ZRL and EOB symbols with their size
// category and amplitude bits; last_of_run marks the final symbol of one input item.
// A classifying front end updates the DC predictor, position and zero count and writes
// one entry per item that produces symbols into a four-entry queue. The back end turns
// each entry into zero to three ZRL symbols and one final symbol held in an output register.
// The first symbol of an item passes through its queue entry and then the output register
// before it is valid. Throughput: one item per clock cycle while the queue is not full; each
// ZRL symbol occupies the single output register on its own, and the queue absorbs
// these. When the receiver stalls, the output register holds and the queue fills; ready
// drops only while the queue holds four entries. Reset clears the predictor, position,
// zero count, queue and output register; no clearing pass is needed.
module jpeg_run_length_symbolizer #(
    parameter int BLOCK_SIDE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rls_coef_if.sink    coefficients,
    rls_sym_if.source   symbols
);
    import rls_pkg::*;

    rls_job_t push_job;
    rls_job_t head;
    logic     push;
    logic     pop;
    logic     empty;
    logic     full;

    // Front end: classifies each coefficient and tracks the block state.
    rls_front #(
        .BLOCK_SIDE (BLOCK_SIDE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .coefficients (coefficients),
        .queue_full   (full),
        .push         (push),
        .job          (push_job)
    );

    // Queue between classification and symbol emission.
    rls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    // Back end: expands each entry into its symbols.
    rls_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .symbols (symbols)
    );

endmodule
